// File: src/sptoi_pkg.sv
// Shared types, constants and the configuration derivation for the strip mapper.
`timescale 1ns / 1ps
package sptoi_pkg;

  localparam int MaxDiesDefault = 16;
  localparam int FifoDepth      = 4;
  localparam int Q2Bits         = 17;

  localparam logic [15:0] NoStrip = 16'hFFFF;

  localparam logic [2:0] RegDieCount    = 3'd0;
  localparam logic [2:0] RegStripsOnDie = 3'd1;
  localparam logic [2:0] RegDieSide     = 3'd2;
  localparam logic [2:0] RegGuardWidth  = 3'd3;
  localparam logic [2:0] RegDieGap      = 3'd4;

  typedef struct packed {
    logic [4:0]  die_count;
    logic [11:0] strips_on_die;
    logic [17:0] die_side;
    logic [15:0] guard_width;
    logic [15:0] die_gap;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    die_count:     5'd4,
    strips_on_die: 12'd384,
    die_side:      18'd91648,
    guard_width:   16'd1024,
    die_gap:       16'd205
  };

  // Geometry quantities that only change on a configuration write.
  typedef struct packed {
    logic [4:0]         n;
    logic [11:0]        s;
    logic [15:0]        gap;
    logic [19:0]        pitch2;
    logic [18:0]        dg;
    logic [16:0]        g2;
    logic [18:0]        active;
    logic [19:0]        dv;
    logic [23:0]        panel;
    logic signed [25:0] limit;
    logic               bad;
  } drv_t;

  typedef struct packed {
    logic        rej;
    logic [24:0] y2;
  } item_t;

  function automatic drv_t sptoi_derive(input cfg_t c, input logic [4:0] n);
    drv_t               r;
    logic [22:0]        nd;
    logic [20:0]        ng;
    logic signed [19:0] act;
    r.n      = n;
    r.s      = c.strips_on_die;
    r.gap    = c.die_gap;
    r.dg     = {1'b0, c.die_side} + {3'b0, c.die_gap};
    r.pitch2 = {r.dg, 1'b0};
    r.g2     = {c.guard_width, 1'b0};
    nd       = n * c.die_side;
    ng       = (n == 5'd0) ? 21'd0 : (n - 5'd1) * c.die_gap;
    r.panel  = {1'b0, nd} + {3'b0, ng};
    r.limit  = $signed({2'b0, r.panel}) - $signed({9'b0, r.g2});
    act      = $signed({2'b0, c.die_side}) - $signed({3'b0, r.g2});
    r.active = act[18:0];
    r.dv     = {act[18:0], 1'b0};
    r.bad    = (n == 5'd0) || (r.pitch2 == 20'd0) || (act <= 20'sd0);
    return r;
  endfunction

endpackage

// File: src/sptoi_cfg.sv
// Configuration registers and the registered geometry derived from them.
`timescale 1ns / 1ps
module sptoi_cfg #(
  parameter int MAX_DIES = sptoi_pkg::MaxDiesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [17:0]       cfg_data,
  output sptoi_pkg::drv_t   drv
);
  import sptoi_pkg::*;

  localparam logic [6:0] MaxN = 7'(MAX_DIES);

  cfg_t        cfg_r, cfg_nxt;
  drv_t        drv_r;
  logic [4:0]  n_cl;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        RegDieCount:    cfg_nxt.die_count     = cfg_data[4:0];
        RegStripsOnDie: cfg_nxt.strips_on_die = cfg_data[11:0];
        RegDieSide:     cfg_nxt.die_side      = cfg_data;
        RegGuardWidth:  cfg_nxt.guard_width   = cfg_data[15:0];
        RegDieGap:      cfg_nxt.die_gap       = cfg_data[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // The derived geometry is loaded from the next register values, so it is
  // current at the same edge as the register write.
  assign n_cl = ({2'b0, cfg_nxt.die_count} > MaxN) ? MaxN[4:0] : cfg_nxt.die_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
      drv_r <= sptoi_derive(CfgReset, CfgReset.die_count);
    end else begin
      cfg_r <= cfg_nxt;
      drv_r <= sptoi_derive(cfg_nxt, n_cl);
    end
  end

  assign drv = drv_r;

endmodule

// File: src/sptoi_front.sv
// Front end: accepts a position and classifies it against the panel outline.
`timescale 1ns / 1ps
module sptoi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [21:0]  in_position,
  input  sptoi_pkg::drv_t     drv,
  input  logic                q_full,
  output logic                push,
  output sptoi_pkg::item_t    item
);
  import sptoi_pkg::*;

  logic [21:0]        ax;
  logic signed [25:0] twoax;
  logic signed [25:0] y2;
  logic               outer;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign ax    = in_position[21] ? 22'(-in_position) : in_position;
  assign twoax = $signed({3'b0, ax, 1'b0});
  assign outer = twoax > drv.limit;
  assign y2    = $signed({{3{in_position[21]}}, in_position, 1'b0})
               + $signed({2'b0, drv.panel});

  always_comb begin
    item.rej = drv.bad || outer || y2[25];
    item.y2  = y2[24:0];
  end

endmodule

// File: src/sptoi_fifo.sv
// Short queue between the classifying front end and the arithmetic back end.
`timescale 1ns / 1ps
module sptoi_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sptoi_pkg::item_t  wr_item,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output sptoi_pkg::item_t  rd_item
);
  import sptoi_pkg::*;

  localparam int PW = $clog2(FifoDepth);

  item_t          mem_r [FifoDepth];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (PW+1)'(FifoDepth));
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/sptoi_back.sv
// Back end: die division, gap checks, strip division and the output register.
`timescale 1ns / 1ps
module sptoi_back #(
  parameter int MAX_DIES = sptoi_pkg::MaxDiesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sptoi_pkg::drv_t   drv,
  input  logic              q_empty,
  input  sptoi_pkg::item_t  q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_strip_index,
  output logic              out_strip_valid
);
  import sptoi_pkg::*;

  localparam int QB = $clog2(MAX_DIES) + 1;
  localparam int W1 = 26 + QB;
  localparam int DW = QB + 12;
  localparam int W2 = 20 + Q2Bits;

  typedef struct packed {
    logic          v;
    logic          rej;
    logic [24:0]   rem;
    logic [QB-1:0] q;
  } d1_t;

  typedef struct packed {
    logic          v;
    logic          rej;
    logic [19:0]   x2m;
    logic [19:0]   w2;
    logic [QB-1:0] q;
  } p1_t;

  typedef struct packed {
    logic          v;
    logic          rej;
    logic [31:0]   prod;
    logic [DW-1:0] dies;
  } p2_t;

  typedef struct packed {
    logic              v;
    logic              rej;
    logic [31:0]       rem;
    logic [Q2Bits-1:0] q;
    logic [DW-1:0]     dies;
  } d2_t;

  logic en;
  d1_t  d1_r [QB+1];
  d1_t  d1_nxt [QB+1];
  p1_t  p1_r, p1_nxt;
  p2_t  p2_r, p2_nxt;
  d2_t  d2_r [Q2Bits+1];
  d2_t  d2_nxt [Q2Bits+1];

  logic        out_valid_r;
  logic [15:0] idx_r;
  logic        sv_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_empty;

  // Die division entry: a quotient beyond QB bits is past every die.
  always_comb begin
    logic [W1-1:0] lim;
    lim = W1'(drv.pitch2) << QB;
    d1_nxt[0].v   = pop;
    d1_nxt[0].rej = q_item.rej || (W1'(q_item.y2) >= lim);
    d1_nxt[0].rem = q_item.y2;
    d1_nxt[0].q   = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_d1
    always_comb begin
      logic [W1-1:0] t;
      logic          ge;
      t  = W1'(drv.pitch2) << (QB - 1 - k);
      ge = W1'(d1_r[k].rem) >= t;
      d1_nxt[k+1]     = d1_r[k];
      if (ge) begin
        d1_nxt[k+1].rem = d1_r[k].rem - t[24:0];
        d1_nxt[k+1].q[QB-1-k] = 1'b1;
      end
    end
  end

  // Remainder gives both the gap position and the offset into the active area.
  always_comb begin
    logic [25:0]        sum;
    logic [25:0]        x2m;
    logic signed [26:0] w2;
    sum = 26'(d1_r[QB].rem) + 26'(drv.gap);
    x2m = (sum >= 26'(drv.pitch2)) ? sum - 26'(drv.pitch2) : sum;
    w2  = $signed({2'b0, d1_r[QB].rem}) - $signed({10'b0, drv.g2});
    p1_nxt.v   = d1_r[QB].v;
    p1_nxt.rej = d1_r[QB].rej || w2[26] || (7'(d1_r[QB].q) >= 7'(drv.n));
    p1_nxt.x2m = x2m[19:0];
    p1_nxt.w2  = w2[19:0];
    p1_nxt.q   = d1_r[QB].q;
  end

  always_comb begin
    logic signed [20:0] e2;
    logic [19:0]        ae;
    e2 = $signed({1'b0, p1_r.x2m}) - $signed({2'b0, drv.dg});
    ae = e2[20] ? 20'(-e2) : e2[19:0];
    p2_nxt.v    = p1_r.v;
    p2_nxt.rej  = p1_r.rej || (20'(drv.active) <= ae);
    p2_nxt.prod = p1_r.w2 * drv.s;
    p2_nxt.dies = p1_r.q * drv.s;
  end

  always_comb begin
    logic [W2-1:0] lim;
    lim = W2'(drv.dv) << Q2Bits;
    d2_nxt[0].v    = p2_r.v;
    d2_nxt[0].rej  = p2_r.rej || (W2'(p2_r.prod) >= lim);
    d2_nxt[0].rem  = p2_r.prod;
    d2_nxt[0].q    = '0;
    d2_nxt[0].dies = p2_r.dies;
  end

  for (genvar k = 0; k < Q2Bits; k++) begin : g_d2
    always_comb begin
      logic [W2-1:0] t;
      logic          ge;
      t  = W2'(drv.dv) << (Q2Bits - 1 - k);
      ge = W2'(d2_r[k].rem) >= t;
      d2_nxt[k+1] = d2_r[k];
      if (ge) begin
        d2_nxt[k+1].rem = d2_r[k].rem - t[31:0];
        d2_nxt[k+1].q[Q2Bits-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        d1_r[i].v <= 1'b0;
      end
      for (int i = 0; i <= Q2Bits; i++) begin
        d2_r[i].v <= 1'b0;
      end
      p1_r.v      <= 1'b0;
      p2_r.v      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      for (int i = 0; i <= QB; i++) begin
        d1_r[i] <= d1_nxt[i];
      end
      for (int i = 0; i <= Q2Bits; i++) begin
        d2_r[i] <= d2_nxt[i];
      end
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      out_valid_r <= d2_r[Q2Bits].v;
    end
  end

  always_ff @(posedge clk) begin
    logic [19:0] strip;
    strip = 20'(d2_r[Q2Bits].q) + 20'(d2_r[Q2Bits].dies);
    if (en) begin
      if (d2_r[Q2Bits].rej || (strip >= 20'(NoStrip))) begin
        idx_r <= NoStrip;
        sv_r  <= 1'b0;
      end else begin
        idx_r <= strip[15:0];
        sv_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_strip_index = idx_r;
  assign out_strip_valid = sv_r;

endmodule

// File: src/strip_position_to_index.sv
// Top level of the position-to-strip mapper.
// Maps a signed position across a row of equal dies (units of 1/1024 mm) to a
// global strip number, or 65535 with strip_valid low when the position falls
// outside the panel, in a gap or on a guard ring. One transaction is taken per
// clock while the queue is not full. The strip comes from two restoring
// dividers (die number and strip within the die) that resolve one quotient
// bit per pipeline stage. A four-entry queue sits between the classifying
// front end and the divider pipeline. A configuration write reaches the
// derived geometry registers at its own edge, so the transaction accepted on
// the next clock already sees it.
`timescale 1ns / 1ps
module strip_position_to_index #(
  parameter int MAX_DIES = sptoi_pkg::MaxDiesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [21:0] in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_strip_index,
  output logic               out_strip_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import sptoi_pkg::*;

  drv_t  drv;
  item_t f_item, q_item;
  logic  push, pop, q_empty, q_full;

  sptoi_cfg #(.MAX_DIES(MAX_DIES)) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .drv(drv)
  );

  sptoi_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_position(in_position), .drv(drv), .q_full(q_full), .push(push),
    .item(f_item)
  );

  sptoi_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_item(f_item), .pop(pop),
    .empty(q_empty), .full(q_full), .rd_item(q_item)
  );

  sptoi_back #(.MAX_DIES(MAX_DIES)) u_back (
    .clk(clk), .rst_n(rst_n), .drv(drv), .q_empty(q_empty), .q_item(q_item),
    .pop(pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_strip_index(out_strip_index), .out_strip_valid(out_strip_valid)
  );

endmodule

// File: src/sptoi_checker.sv
// Port-level checks for the strip mapper, bound to the top level.
`timescale 1ns / 1ps
module sptoi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_strip_index,
  input logic        out_strip_valid
);
  import sptoi_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_strip_valid |-> out_strip_index == NoStrip)
    else $error("rejected transaction without the no-strip code");

  a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strip_valid |-> out_strip_index != NoStrip)
    else $error("valid strip carries the no-strip code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_strip_index)
      && $stable(out_strip_valid))
    else $error("stalled result changed");

endmodule

bind strip_position_to_index sptoi_checker u_sptoi_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_strip_index(out_strip_index), .out_strip_valid(out_strip_valid)
);

// File: sim/strip_position_to_index_tb.sv
// Self-checking testbench for the position-to-strip mapper.
`timescale 1ns / 1ps
module strip_position_to_index_tb;
  import sptoi_pkg::*;

  typedef struct {
    logic [15:0] strip_index;
    logic        strip_valid;
  } strip_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [21:0] in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_strip_index;
  logic               out_strip_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [17:0]        cfg_data = '0;

  strip_position_to_index u_dut (.*);

  always #1 clk = ~clk;

  // Geometry as the predictor sees it.
  int unsigned geo_count, geo_strips, geo_side, geo_guard, geo_gap;

  logic signed [21:0] pending_positions[$];
  strip_result_t      expected_strips[$];
  int                 fail_count = 0;
  bit                 idle_enable = 1'b0;
  int                 hold_off = 0;
  int                 quiet_cycles = 0;

  // Directed: extremes, panel center, outer edge, guard and gap edges.
  logic signed [21:0] directed_positions[17] = '{
    22'sh1FFFFF, 22'sh200000, 22'sd0, 22'sd1, -22'sd1, 22'sd183808,
    -22'sd183808, 22'sd182784, -22'sd182784, 22'sd182783, 22'sd102,
    -22'sd103, 22'sd1127, 22'sd1126, 22'sd91750, 22'sh2AAAAA, 22'sh155555};

  function automatic strip_result_t map_position(input logic signed [21:0] pos);
    strip_result_t r;
    longint x, n, d, g, gp, s, panel, pitch2, act, x2, edge2, y2, die, w2, strip, ax;
    r.strip_index = NoStrip;
    r.strip_valid = 1'b0;
    x = pos;
    n = (geo_count > 16) ? 16 : geo_count;
    d = geo_side; g = geo_guard; gp = geo_gap; s = geo_strips;
    if (n == 0) return r;
    panel = n * d + (n - 1) * gp;
    pitch2 = 2 * (d + gp);
    act = d - 2 * g;
    if (pitch2 == 0 || act <= 0) return r;
    ax = (x < 0) ? -x : x;
    if (2 * ax > panel - 2 * g) return r;
    x2 = 2 * x + panel + gp;
    if (x2 < 0) return r;
    edge2 = (x2 % pitch2) - (d + gp);
    if (edge2 < 0) edge2 = -edge2;
    if (act <= edge2) return r;
    y2 = 2 * x + panel;
    if (y2 < 0) return r;
    die = y2 / pitch2;
    if (die >= n) return r;
    w2 = (y2 % pitch2) - 2 * g;
    if (w2 < 0) return r;
    strip = (w2 * s) / (2 * act) + die * s;
    if (strip < 0 || strip >= 65535) return r;
    r.strip_index = strip[15:0];
    r.strip_valid = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_strips.push_back(map_position(in_position));
      void'(pending_positions.pop_front());
    end
    if (!in_valid || in_ready) begin
      if (pending_positions.size() > 0 && !(idle_enable && $urandom_range(99) < 18)) begin
        in_valid <= 1'b1;
        in_position <= pending_positions[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_strips.size() == 0) begin
        $error("unexpected result: strip_index %0d", out_strip_index);
        fail_count++;
      end else begin
        strip_result_t e;
        e = expected_strips.pop_front();
        if (out_strip_index !== e.strip_index) begin
          $error("strip_index expected %0d actual %0d", e.strip_index, out_strip_index);
          fail_count++;
        end
        if (out_strip_valid !== e.strip_valid) begin
          $error("strip_valid expected %0d actual %0d", e.strip_valid, out_strip_valid);
          fail_count++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_enable && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[17:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegDieCount:    geo_count = value & 32'h1F;
      RegStripsOnDie: geo_strips = value & 32'hFFF;
      RegDieSide:     geo_side = value & 32'h3FFFF;
      RegGuardWidth:  geo_guard = value & 32'hFFFF;
      default:        geo_gap = value & 32'hFFFF;
    endcase
  endtask

  task automatic drain_results;
    while (pending_positions.size() != 0 || in_valid || expected_strips.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned cnt, input int unsigned strips,
                              input int unsigned side, input int unsigned guard,
                              input int unsigned gap);
    drain_results();
    write_reg(RegDieCount, cnt);
    write_reg(RegStripsOnDie, strips);
    write_reg(RegDieSide, side);
    write_reg(RegGuardWidth, guard);
    write_reg(RegDieGap, gap);
    cfg_valid <= 1'b0;
  endtask

  // Positions biased toward the populated part of the panel.
  task automatic queue_random(input int count);
    longint half;
    int     pick;
    half = ((geo_count > 16 ? 16 : geo_count) * geo_side
            + geo_gap * (geo_count > 0 ? geo_count : 1)) / 2 + 16;
    if (half > 2097151) half = 2097151;
    repeat (count) begin
      pick = $urandom_range(9);
      if (pick < 8)
        pending_positions.push_back(22'($signed($urandom_range(2 * half)) - half));
      else
        pending_positions.push_back(22'($urandom));
    end
  endtask

  initial begin
    geo_count = CfgReset.die_count;
    geo_strips = CfgReset.strips_on_die;
    geo_side = CfgReset.die_side;
    geo_guard = CfgReset.guard_width;
    geo_gap = CfgReset.die_gap;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_positions[i])
      pending_positions.push_back(directed_positions[i]);
    queue_random(80);
    drain_results();

    // Pressure: receiver holds off while the sender keeps offering.
    hold_off = 200;
    queue_random(60);
    drain_results();
    idle_enable = 1'b1;
    queue_random(150);

    set_geometry(31, 4095, 262143, 0, 65535);        // clamped dies, overflow
    queue_random(100);
    set_geometry(0, 1, 1000, 0, 0);                  // no dies
    queue_random(20);
    set_geometry(1, 0, 0, 0, 0);                     // zero pitch
    queue_random(20);
    set_geometry(3, 0, 4000, 100, 50);               // no strips
    queue_random(80);
    set_geometry(2, 7, 4000, 2000, 10);              // guard too wide
    queue_random(20);
    set_geometry(1, 1, 262143, 65535, 0);
    queue_random(80);
    set_geometry(16, 4095, 8000, 30, 300);
    queue_random(120);
    set_geometry(5, 123, 20000, 777, 4000);
    queue_random(200);
    drain_results();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
src/sptoi_pkg.sv
src/sptoi_cfg.sv
src/sptoi_front.sv
src/sptoi_fifo.sv
src/sptoi_back.sv
src/strip_position_to_index.sv
src/sptoi_checker.sv
sim/strip_position_to_index_tb.sv
